// ----- rtl/lep_pkg.sv -----
package lep_pkg;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MAP1,
      ST_MAP2,
      ST_MAP3,
      ST_DER,
      ST_ABS,
      ST_NORM,
      ST_SQ_FIRST,
      ST_SQ,
      ST_LN,
      ST_ACC,
      ST_DIV_INIT,
      ST_DIV,
      ST_SAT,
      ST_TMUL,
      ST_FINISH
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_SUM_INIT,
      OP_MAP1,
      OP_MAP2,
      OP_MAP3,
      OP_DER,
      OP_ABS,
      OP_NORM,
      OP_SQ_FIRST,
      OP_SQ,
      OP_LN,
      OP_ACC,
      OP_DIV_INIT,
      OP_DIV,
      OP_SAT,
      OP_TMUL,
      OP_OUT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic cnt_zero;
      logic iter_last;
      logic d_zero;
      logic out_free;
   } status_type;

   localparam logic [2:0] REG_RATE_PATTERN   = 3'd0;
   localparam logic [2:0] REG_PATTERN_LENGTH = 3'd1;
   localparam logic [2:0] REG_WARMUP_STEPS   = 3'd2;
   localparam logic [2:0] REG_SUM_STEPS      = 3'd3;
   localparam logic [2:0] REG_SEED_VALUE     = 3'd4;

   localparam logic signed [32:0] ONE_Q30   = 33'sd1073741824;
   localparam logic signed [32:0] LN2_Q30   = 33'sd744261118;
   localparam logic signed [32:0] RECIP3    = 33'sd699051;
   localparam logic signed [39:0] X_HI      = 40'sd2147483648;
   localparam logic signed [39:0] X_LO      = -40'sd2147483648;
   localparam logic [38:0]        EXP_POS   = 39'd524287;
   localparam logic [38:0]        EXP_NEG   = 39'd524288;
   localparam logic [5:0]         NORM_LAST = 6'd5;
   localparam logic [5:0]         DIV_LAST  = 6'd38;
   localparam logic [5:0]         E_START   = 6'd62;
   localparam logic [6:0]         E_BIAS    = 7'd56;

endpackage

// ----- rtl/lyapunov_exponent_pixel_unit.sv -----
// Lyapunov exponent of one fractal pixel, logistic map with an A/B rate pattern.
// req channel: one beat carries rate_a (tdata[31:0]) and rate_b (tdata[63:32]),
// both signed Q3.28. rsp channel: one beat per request with exponent (Q3.16,
// saturated) in tdata[19:0] and palette_level (Q0.16) in tdata[35:20].
// csr port: 64-bit registers at byte 8*i: rate_pattern, pattern_length,
// warmup_steps, sum_steps, seed_value. Write them only while the unit is idle.
// One shared 33x33 multiplier carries every product. A warm-up step runs the map,
// an accumulated step runs the map, the derivative, a 6-step shift search and
// 2*LOG_TABLE_BITS squarings, or only the map and derivative when the derivative
// is zero; a final division by sum_steps then gives the exponent.
// One request is worked at a time; req_tready is high only while idle, so a new
// request is not taken until the previous result has entered the output register.
// The result sits in an output register, so the next request is taken while
// it waits; if rsp_tready stays low, the following result holds until it drains.
// Reset restores the register defaults and empties the output register.
module lyapunov_exponent_pixel_unit #(
   parameter int PATTERN_BITS   = 64,
   parameter int LOG_TABLE_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // rate_a, rate_b
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // exponent, palette_level, zero pad
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   import lep_pkg::*;

   cmd_type                 cmd;
   status_type              status;
   logic [PATTERN_BITS-1:0] rate_pattern;
   logic [6:0]              pattern_length;
   logic [15:0]             warmup_steps;
   logic [15:0]             sum_steps;
   logic [30:0]             seed_value;

   lep_csr #(.PATTERN_BITS(PATTERN_BITS)) u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .rate_pattern   (rate_pattern),
      .pattern_length (pattern_length),
      .warmup_steps   (warmup_steps),
      .sum_steps      (sum_steps),
      .seed_value     (seed_value)
   );

   lep_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lep_datapath #(
      .PATTERN_BITS   (PATTERN_BITS),
      .LOG_TABLE_BITS (LOG_TABLE_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_tdata      (req_tdata),
      .rate_pattern   (rate_pattern),
      .pattern_length (pattern_length),
      .warmup_steps   (warmup_steps),
      .sum_steps      (sum_steps),
      .seed_value     (seed_value),
      .rsp_tready     (rsp_tready),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tdata      (rsp_tdata)
   );

endmodule

// ----- rtl/lep_csr.sv -----
module lep_csr #(
   parameter int PATTERN_BITS = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [5:0]              csr_paddr,
   input  logic [63:0]             csr_pwdata,
   output logic [63:0]             csr_prdata,
   output logic                    csr_pready,
   output logic [PATTERN_BITS-1:0] rate_pattern,
   output logic [6:0]              pattern_length,
   output logic [15:0]             warmup_steps,
   output logic [15:0]             sum_steps,
   output logic [30:0]             seed_value
);
   import lep_pkg::*;

   logic [PATTERN_BITS-1:0] pattern_ff;
   logic [6:0]              length_ff;
   logic [15:0]             warmup_ff;
   logic [15:0]             sums_ff;
   logic [30:0]             seed_ff;
   logic                    wr_en;
   logic [2:0]              idx;

   assign csr_pready = 1'b1;
   assign idx        = csr_paddr[5:3];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= PATTERN_BITS'(2);
         length_ff  <= 7'd2;
         warmup_ff  <= 16'd100;
         sums_ff    <= 16'd500;
         seed_ff    <= 31'd536870912;
      end else if (wr_en) begin
         case (idx)
            REG_RATE_PATTERN:   pattern_ff <= csr_pwdata[PATTERN_BITS-1:0];
            REG_PATTERN_LENGTH: length_ff  <= csr_pwdata[6:0];
            REG_WARMUP_STEPS:   warmup_ff  <= csr_pwdata[15:0];
            REG_SUM_STEPS:      sums_ff    <= csr_pwdata[15:0];
            REG_SEED_VALUE:     seed_ff    <= csr_pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (idx)
         REG_RATE_PATTERN:   csr_prdata = 64'(pattern_ff);
         REG_PATTERN_LENGTH: csr_prdata = 64'(length_ff);
         REG_WARMUP_STEPS:   csr_prdata = 64'(warmup_ff);
         REG_SUM_STEPS:      csr_prdata = 64'(sums_ff);
         REG_SEED_VALUE:     csr_prdata = 64'(seed_ff);
         default:            csr_prdata = '0;
      endcase
   end

   assign rate_pattern   = pattern_ff;
   assign pattern_length = length_ff;
   assign warmup_steps   = warmup_ff;
   assign sum_steps      = sums_ff;
   assign seed_value     = seed_ff;

endmodule

// ----- rtl/lep_ctrl.sv -----
module lep_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  lep_pkg::status_type status,
   output lep_pkg::cmd_type    cmd
);
   import lep_pkg::*;

   state_type state_ff, state_in;
   logic      sum_phase_ff, sum_phase_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_phase_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_phase_ff <= sum_phase_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      sum_phase_in = sum_phase_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in     = ST_CHECK;
               sum_phase_in = 1'b0;
            end
         end
         ST_CHECK: begin
            if (!status.cnt_zero) begin
               state_in = ST_MAP1;
            end else if (!sum_phase_ff) begin
               sum_phase_in = 1'b1;
            end else begin
               state_in = ST_DIV_INIT;
            end
         end
         ST_MAP1:     state_in = ST_MAP2;
         ST_MAP2:     state_in = ST_MAP3;
         ST_MAP3:     state_in = sum_phase_ff ? ST_DER : ST_CHECK;
         ST_DER:      state_in = ST_ABS;
         ST_ABS:      state_in = status.d_zero ? ST_CHECK : ST_NORM;
         ST_NORM:     state_in = status.iter_last ? ST_SQ_FIRST : ST_NORM;
         ST_SQ_FIRST: state_in = ST_SQ;
         ST_SQ:       state_in = status.iter_last ? ST_LN : ST_SQ;
         ST_LN:       state_in = ST_ACC;
         ST_ACC:      state_in = ST_CHECK;
         ST_DIV_INIT: state_in = ST_DIV;
         ST_DIV:      state_in = status.iter_last ? ST_SAT : ST_DIV;
         ST_SAT:      state_in = ST_TMUL;
         ST_TMUL:     state_in = ST_FINISH;
         ST_FINISH:   state_in = status.out_free ? ST_IDLE : ST_FINISH;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.op     = OP_NONE;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) cmd.op = OP_LOAD;
         end
         ST_CHECK: begin
            if (status.cnt_zero && !sum_phase_ff) cmd.op = OP_SUM_INIT;
         end
         ST_MAP1:     cmd.op = OP_MAP1;
         ST_MAP2:     cmd.op = OP_MAP2;
         ST_MAP3:     cmd.op = OP_MAP3;
         ST_DER:      cmd.op = OP_DER;
         ST_ABS:      cmd.op = OP_ABS;
         ST_NORM:     cmd.op = OP_NORM;
         ST_SQ_FIRST: cmd.op = OP_SQ_FIRST;
         ST_SQ:       cmd.op = OP_SQ;
         ST_LN:       cmd.op = OP_LN;
         ST_ACC:      cmd.op = OP_ACC;
         ST_DIV_INIT: cmd.op = OP_DIV_INIT;
         ST_DIV:      cmd.op = OP_DIV;
         ST_SAT:      cmd.op = OP_SAT;
         ST_TMUL:     cmd.op = OP_TMUL;
         ST_FINISH: begin
            if (status.out_free) cmd.op = OP_OUT;
         end
         default:     cmd.op = OP_NONE;
      endcase
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_CHECK))
      else $error("accepted beat did not start a run");

   a_out_slot_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_OUT) |-> status.out_free)
      else $error("result written over an undelivered beat");

   a_finish_to_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && status.out_free) |=> (state_ff == ST_IDLE))
      else $error("finish did not return to idle");

endmodule

// ----- rtl/lep_datapath.sv -----
module lep_datapath #(
   parameter int PATTERN_BITS   = 64,
   parameter int LOG_TABLE_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  lep_pkg::cmd_type        cmd,
   output lep_pkg::status_type     status,
   input  logic [63:0]             req_tdata,
   input  logic [PATTERN_BITS-1:0] rate_pattern,
   input  logic [6:0]              pattern_length,
   input  logic [15:0]             warmup_steps,
   input  logic [15:0]             sum_steps,
   input  logic [30:0]             seed_value,
   input  logic                    rsp_tready,
   output logic                    rsp_tvalid,
   output logic [39:0]             rsp_tdata
);
   import lep_pkg::*;

   localparam int FBITS = 2 * LOG_TABLE_BITS;
   localparam int PTR_W = (PATTERN_BITS > 1) ? $clog2(PATTERN_BITS) : 1;
   localparam logic [6:0] PAT_MAX  = 7'(PATTERN_BITS);
   localparam logic [5:0] SQ_LAST  = 6'(FBITS - 1);
   localparam int         FR_SHIFT = 24 - FBITS;

   logic signed [31:0] rate_a_ff, rate_a_in, rate_b_ff, rate_b_in, r_ff, r_in;
   logic signed [32:0] x_ff, x_in, q_ff, q_in;
   logic signed [65:0] prod_ff, prod_in;
   logic [15:0]        cnt_ff, cnt_in;
   logic [PTR_W-1:0]   ptr_ff, ptr_in;
   logic [5:0]         iter_ff, iter_in;
   logic [62:0]        norm_ff, norm_in;
   logic [5:0]         e_ff, e_in;
   logic [FBITS-1:0]   frac_ff, frac_in;
   logic signed [47:0] sum_ff, sum_in;
   logic [38:0]        quo_ff, quo_in;
   logic [16:0]        rem_ff, rem_in;
   logic               neg_ff, neg_in;
   logic signed [19:0] lam_ff, lam_in;
   logic [19:0]        v_ff, v_in;
   logic [19:0]        exp_ff, exp_in;
   logic [15:0]        pal_ff, pal_in;
   logic               valid_ff, valid_in;

   logic signed [32:0] mul_a, mul_b;
   logic               mul_en;
   logic [6:0]         len_eff, ptr_last;
   logic [PTR_W-1:0]   ptr_next;
   logic signed [39:0] xs;
   logic signed [34:0] qt;
   logic signed [65:0] dabs;
   logic [5:0]         amt;
   logic [6:0]         top_pos;
   logic [31:0]        sq;
   logic [30:0]        ynew;
   logic signed [6:0]  em;
   logic [23:0]        frac_ext;
   logic signed [30:0] l2;
   logic signed [47:0] mag;
   logic [16:0]        shifted;
   logic [17:0]        diff;
   logic [19:0]        tq;

   always_comb begin
      if (pattern_length == 7'd0)          len_eff = 7'd1;
      else if (pattern_length > PAT_MAX)   len_eff = PAT_MAX;
      else                                 len_eff = pattern_length;
      ptr_last = len_eff - 7'd1;
      ptr_next = (7'(ptr_ff) == ptr_last) ? '0 : ptr_ff + PTR_W'(1);
   end

   always_comb begin
      xs       = prod_ff[65:26];
      sq       = prod_ff[61:30];
      ynew     = sq[31] ? sq[31:1] : sq[30:0];
      dabs     = prod_ff[65] ? -prod_ff : prod_ff;
      amt      = 6'd32 >> iter_ff;
      top_pos  = 7'd63 - 7'(amt);
      em       = signed'({1'b0, e_ff}) - signed'(E_BIAS);
      frac_ext = 24'(frac_ff) << FR_SHIFT;
      l2       = signed'({em, 24'b0}) + signed'({7'b0, frac_ext});
      mag      = sum_ff[47] ? -sum_ff : sum_ff;
      shifted  = {rem_ff[15:0], quo_ff[38]};
      diff     = {1'b0, shifted} - {2'b0, sum_steps};
      tq       = prod_ff[40:21];
   end

   always_comb begin
      rate_a_in = rate_a_ff;
      rate_b_in = rate_b_ff;
      r_in      = r_ff;
      x_in      = x_ff;
      q_in      = q_ff;
      cnt_in    = cnt_ff;
      ptr_in    = ptr_ff;
      iter_in   = iter_ff;
      norm_in   = norm_ff;
      e_in      = e_ff;
      frac_in   = frac_ff;
      sum_in    = sum_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      neg_in    = neg_ff;
      lam_in    = lam_ff;
      v_in      = v_ff;
      exp_in    = exp_ff;
      pal_in    = pal_ff;
      valid_in  = valid_ff && !rsp_tready;
      mul_a     = '0;
      mul_b     = '0;
      mul_en    = 1'b0;
      qt        = '0;
      unique case (cmd.op)
         OP_NONE: ;
         OP_LOAD: begin
            rate_a_in = req_tdata[31:0];
            rate_b_in = req_tdata[63:32];
            x_in      = {2'b00, seed_value};
            cnt_in    = warmup_steps;
            ptr_in    = '0;
            sum_in    = '0;
         end
         OP_SUM_INIT: begin
            cnt_in = sum_steps;
            ptr_in = '0;
         end
         OP_MAP1: begin
            r_in   = rate_pattern[ptr_ff] ? rate_b_ff : rate_a_ff;
            mul_a  = x_ff;
            mul_b  = ONE_Q30 - x_ff;
            mul_en = 1'b1;
         end
         OP_MAP2: begin
            mul_a  = {r_ff[31], r_ff};
            mul_b  = {prod_ff[63], prod_ff[63:32]};
            mul_en = 1'b1;
         end
         OP_MAP3: begin
            if (xs > X_HI)      x_in = X_HI[32:0];
            else if (xs < X_LO) x_in = X_LO[32:0];
            else                x_in = xs[32:0];
            qt     = 35'sd1073741824 - (35'(x_in) <<< 1);
            q_in   = qt[34:2];
            cnt_in = cnt_ff - 16'd1;
            ptr_in = ptr_next;
         end
         OP_DER: begin
            mul_a  = {r_ff[31], r_ff};
            mul_b  = q_ff;
            mul_en = 1'b1;
         end
         OP_ABS: begin
            norm_in = dabs[62:0];
            e_in    = E_START;
            iter_in = '0;
         end
         OP_NORM: begin
            if ((norm_ff >> top_pos) == 63'd0) begin
               norm_in = norm_ff << amt;
               e_in    = e_ff - amt;
            end
            iter_in = iter_ff + 6'd1;
         end
         OP_SQ_FIRST: begin
            mul_a   = {2'b00, norm_ff[62:32]};
            mul_b   = {2'b00, norm_ff[62:32]};
            mul_en  = 1'b1;
            iter_in = '0;
            frac_in = '0;
         end
         OP_SQ: begin
            frac_in = {frac_ff[FBITS-2:0], sq[31]};
            mul_a   = {2'b00, ynew};
            mul_b   = {2'b00, ynew};
            mul_en  = 1'b1;
            iter_in = iter_ff + 6'd1;
         end
         OP_LN: begin
            mul_a  = 33'(l2);
            mul_b  = LN2_Q30;
            mul_en = 1'b1;
         end
         OP_ACC: begin
            sum_in = sum_ff + {{12{prod_ff[65]}}, prod_ff[65:30]};
         end
         OP_DIV_INIT: begin
            quo_in  = mag[46:8];
            rem_in  = '0;
            neg_in  = sum_ff[47];
            iter_in = '0;
         end
         OP_DIV: begin
            rem_in  = diff[17] ? shifted : diff[16:0];
            quo_in  = {quo_ff[37:0], !diff[17]};
            iter_in = iter_ff + 6'd1;
         end
         OP_SAT: begin
            if (sum_steps == 16'd0) begin
               lam_in = '0;
               v_in   = '0;
            end else if (!neg_ff) begin
               lam_in = (quo_ff > EXP_POS) ? EXP_POS[19:0] : quo_ff[19:0];
               v_in   = '0;
            end else begin
               v_in   = (quo_ff > EXP_NEG) ? EXP_NEG[19:0] : quo_ff[19:0];
               lam_in = -signed'(v_in);
            end
         end
         OP_TMUL: begin
            mul_a  = {13'b0, v_ff};
            mul_b  = RECIP3;
            mul_en = 1'b1;
         end
         OP_OUT: begin
            exp_in   = lam_ff;
            pal_in   = (tq > 20'd65535) ? 16'hFFFF : tq[15:0];
            valid_in = 1'b1;
         end
         default: ;
      endcase
      prod_in = mul_en ? (mul_a * mul_b) : prod_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      rate_a_ff <= rate_a_in;
      rate_b_ff <= rate_b_in;
      r_ff      <= r_in;
      x_ff      <= x_in;
      q_ff      <= q_in;
      prod_ff   <= prod_in;
      cnt_ff    <= cnt_in;
      ptr_ff    <= ptr_in;
      iter_ff   <= iter_in;
      norm_ff   <= norm_in;
      e_ff      <= e_in;
      frac_ff   <= frac_in;
      sum_ff    <= sum_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      neg_ff    <= neg_in;
      lam_ff    <= lam_in;
      v_ff      <= v_in;
      exp_ff    <= exp_in;
      pal_ff    <= pal_in;
   end

   always_comb begin
      status.cnt_zero = (cnt_ff == 16'd0);
      status.d_zero   = (prod_ff == '0);
      status.out_free = !valid_ff || rsp_tready;
      unique case (cmd.op)
         OP_NORM: status.iter_last = (iter_ff == NORM_LAST);
         OP_SQ:   status.iter_last = (iter_ff == SQ_LAST);
         OP_DIV:  status.iter_last = (iter_ff == DIV_LAST);
         default: status.iter_last = 1'b0;
      endcase
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {4'b0, pal_ff, exp_ff};

   a_norm_done: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_NORM && status.iter_last) |=> norm_ff[62])
      else $error("mantissa not normalised after shift search");

   a_square_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_SQ) |-> (sq[31] || sq[30]))
      else $error("squared mantissa fell below one");

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_DIV && sum_steps != 16'd0) |=> (rem_ff < {1'b0, sum_steps}))
      else $error("divider remainder not below divisor");

endmodule

// ----- dv/lyapunov_exponent_pixel_unit_tb.sv -----
module lyapunov_exponent_pixel_unit_tb;
   import lep_pkg::*;

   localparam int       LOG_BITS  = 8;
   localparam int       PAT_BITS  = 64;
   localparam longint   Q30_ONE   = 64'sd1073741824;
   localparam longint   X_BOUND   = 64'sd2147483648;
   localparam longint   LN2_FIX   = 64'sd744261118;
   localparam longint   LAMBDA_HI = 64'sd524287;
   localparam longint   LAMBDA_LO = -64'sd524288;
   localparam logic [2:0] REG_SPARE = 3'd6;

   typedef struct packed {
      logic [31:0] rate_b;
      logic [31:0] rate_a;
   } pixel_rates_t;

   typedef struct packed {
      logic [19:0] exponent;
      logic [15:0] level;
   } pixel_result_t;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // rate_a, rate_b
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // exponent, palette_level, zero pad
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [5:0]  csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   lyapunov_exponent_pixel_unit uut (.*);

   // register mirror
   logic [63:0] rate_pattern_m = 64'd2;
   logic [6:0]  pattern_len_m  = 7'd2;
   logic [15:0] warmup_m       = 16'd100;
   logic [15:0] sum_steps_m    = 16'd500;
   logic [30:0] seed_m         = 31'd536870912;

   pixel_rates_t  pixels_pending[$];
   pixel_result_t pixel_results_due[$];
   int  failures = 0;
   int  pixels_sent = 0;
   int  results_checked = 0;
   int  phases_run = 0;
   bit  no_gaps = 0;
   bit  req_done = 1'b1;
   int  req_gap = 0;
   int  rsp_gap = 0;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic int draw_gap();
      return no_gaps ? 0 : $urandom_range(0, 8);
   endfunction

   function automatic longint map_next(longint x, longint r);
      longint p;
      longint v;
      p = (x * (Q30_ONE - x)) >>> 30;
      p = p >>> 2;
      v = (r * p) >>> 26;
      if (v > X_BOUND) v = X_BOUND;
      if (v < -X_BOUND) v = -X_BOUND;
      return v;
   endfunction

   function automatic longint ln_fixed(longint unsigned d);
      int              e;
      longint unsigned y;
      longint unsigned frac;
      longint          l2;
      e = 0;
      frac = 0;
      while (e < 63 && (d >> (e + 1)) != 0) e++;
      y = (e >= 30) ? (d >> (e - 30)) : (d << (30 - e));
      for (int i = 0; i < 2 * LOG_BITS; i++) begin
         y = (y * y) >> 30;
         frac = frac << 1;
         if (y >= (64'd2 << 30)) begin
            frac = frac | 1;
            y = y >> 1;
         end
      end
      l2 = (longint'(e) - 56) * 64'sd16777216 + longint'(frac << (24 - 2 * LOG_BITS));
      return (l2 * LN2_FIX) >>> 30;
   endfunction

   function automatic pixel_result_t lyapunov_predict(pixel_rates_t px);
      longint          ra;
      longint          rb;
      longint          r;
      longint          x;
      longint          acc;
      longint          lam;
      longint          t;
      longint          dv;
      longint unsigned d;
      int              len;
      pixel_result_t   res;
      ra = longint'($signed(px.rate_a));
      rb = longint'($signed(px.rate_b));
      len = pattern_len_m;
      if (len == 0) len = 1;
      if (len > PAT_BITS) len = PAT_BITS;
      x = longint'(seed_m);
      acc = 0;
      lam = 0;
      t = 0;
      for (int n = 0; n < warmup_m; n++)
         x = map_next(x, rate_pattern_m[n % len] ? rb : ra);
      for (int n = 0; n < sum_steps_m; n++) begin
         r = rate_pattern_m[n % len] ? rb : ra;
         x = map_next(x, r);
         dv = r * ((Q30_ONE - 2 * x) >>> 2);
         d = (dv < 0) ? longint'(-dv) : dv;
         if (d != 0) acc += ln_fixed(d);
      end
      if (sum_steps_m != 0) lam = acc / (longint'(sum_steps_m) * 256);
      if (lam > LAMBDA_HI) lam = LAMBDA_HI;
      if (lam < LAMBDA_LO) lam = LAMBDA_LO;
      if (lam < 0) begin
         t = (-lam) / 3;
         if (t > 65535) t = 65535;
      end
      res.exponent = lam[19:0];
      res.level = t[15:0];
      return res;
   endfunction

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_done) begin
         // hold
      end else if (req_gap > 0) begin
         req_gap--;
         req_tvalid <= 1'b0;
      end else if (pixels_pending.size() > 0) begin
         req_tdata <= pixels_pending.pop_front();
         req_done = 1'b0;
         req_gap = draw_gap();
         req_tvalid <= 1'b1;
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // result back-pressure
   always @(negedge clock) begin
      if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor
   always @(posedge clock) begin
      pixel_result_t want;
      pixel_result_t got;
      if (!reset) begin
         if (req_tvalid && req_tready && !req_done) begin
            req_done = 1'b1;
            pixel_results_due.push_back(lyapunov_predict(req_tdata));
            pixels_sent++;
         end
         if (rsp_tvalid && rsp_tready) begin
            rsp_gap = draw_gap();
            got.exponent = rsp_tdata[19:0];
            got.level = rsp_tdata[35:20];
            if (pixel_results_due.size() == 0) begin
               $error("result beat with nothing expected: %h", rsp_tdata);
               failures++;
            end else begin
               want = pixel_results_due.pop_front();
               results_checked++;
               if (got.exponent !== want.exponent) begin
                  $error("exponent expected %h got %h", want.exponent, got.exponent);
                  failures++;
               end
               if (got.level !== want.level) begin
                  $error("palette_level expected %h got %h", want.level, got.level);
                  failures++;
               end
            end
         end
      end
   end

   task automatic wait_idle();
      wait (pixels_pending.size() == 0 && req_done && pixel_results_due.size() == 0);
      repeat (8) @(negedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [63:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      case (idx)
         REG_RATE_PATTERN:   rate_pattern_m = value;
         REG_PATTERN_LENGTH: pattern_len_m = value[6:0];
         REG_WARMUP_STEPS:   warmup_m = value[15:0];
         REG_SUM_STEPS:      sum_steps_m = value[15:0];
         REG_SEED_VALUE:     seed_m = value[30:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_config(logic [63:0] pat, logic [6:0] len, logic [15:0] warm,
                             logic [15:0] steps, logic [30:0] seed);
      wait_idle();
      csr_write(REG_RATE_PATTERN, pat);
      csr_write(REG_PATTERN_LENGTH, {57'd0, len});
      csr_write(REG_WARMUP_STEPS, {48'd0, warm});
      csr_write(REG_SUM_STEPS, {48'd0, steps});
      csr_write(REG_SEED_VALUE, {33'd0, seed});
      phases_run++;
   endtask

   task automatic push_pixel(logic [31:0] ra, logic [31:0] rb);
      pixel_rates_t px;
      px.rate_a = ra;
      px.rate_b = rb;
      pixels_pending.push_back(px);
   endtask

   function automatic logic [31:0] rand_rate();
      if ($urandom_range(0, 9) < 7) return $urandom_range(0, 32'h4000_0000);
      return $urandom;
   endfunction

   initial begin
      logic [31:0] directed_a[12] = '{32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h4000_0000,
                                      32'h2000_0000, 32'h2800_0000, 32'h1, 32'hFFFF_FFFF,
                                      32'h3800_0000, 32'h1000_0000, 32'hC000_0000,
                                      32'h3A00_0000};
      logic [31:0] directed_b[12] = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h4000_0000,
                                      32'h2000_0000, 32'h2800_0000, 32'h1, 32'h1,
                                      32'h2800_0000, 32'h3000_0000, 32'h4000_0000,
                                      32'h3500_0000};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset defaults
      push_pixel(32'h3800_0000, 32'h3400_0000);
      push_pixel(32'h2C00_0000, 32'h3C00_0000);

      set_config(64'h6, 7'd4, 16'd6, 16'd8, 31'h2000_0000);
      foreach (directed_a[i]) push_pixel(directed_a[i], directed_b[i]);
      set_config(64'hFFFF_FFFF_FFFF_FFFF, 7'd0, 16'd0, 16'd1, 31'h0);
      push_pixel(32'h3000_0000, 32'h2000_0000);
      push_pixel(32'h4000_0000, 32'h1);
      set_config(64'h0, 7'd127, 16'd3, 16'd0, 31'h4000_0000);
      push_pixel(32'h3800_0000, 32'h2800_0000);
      push_pixel(32'h8000_0000, 32'h7FFF_FFFF);
      set_config(64'hA5A5_5A5A_0F0F_F0F0, 7'd64, 16'd65535, 16'd1, 31'h7FFF_FFFF);
      push_pixel(32'h3900_0000, 32'h2A00_0000);
      set_config(64'h1, 7'd1, 16'd0, 16'd4096, 31'h1234_5678);
      push_pixel(32'h3600_0000, 32'h3600_0000);
      wait_idle();
      csr_write(REG_SPARE, 64'hDEAD_BEEF_DEAD_BEEF);

      for (int ph = 0; ph < 8; ph++) begin
         set_config({$urandom, $urandom}, 7'($urandom_range(1, 64)),
                    16'($urandom_range(0, 30)), 16'($urandom_range(1, 12)),
                    31'($urandom_range(0, 32'h4000_0000)));
         no_gaps = (ph % 3 == 2);
         for (int i = 0; i < 30; i++) push_pixel(rand_rate(), rand_rate());
      end

      wait_idle();
      repeat (100) @(posedge clock);
      $display("pixels %0d, results checked %0d, over %0d register settings",
               pixels_sent, results_checked, phases_run);
      $display("covered pattern lengths 0..127, zero sum steps, long warm-up, saturation");
      if (failures == 0 && pixel_results_due.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
